[hdl/ncq_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest centroid quantizer package
// Shared widths, command codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ncq_pkg;

   // Table geometry
   localparam int NUM_LISTS = 16;
   localparam int VEC_DIM   = 64;

   // Field widths
   localparam int CIDX_W   = 4;
   localparam int EIDX_W   = 6;
   localparam int VALUE_W  = 16;
   localparam int ACTIVE_W = 5;
   localparam int SUM_W    = 38;
   localparam int ADIFF_W  = VALUE_W;
   localparam int SQ_W     = 2 * ADIFF_W;
   localparam int ADDR_W   = CIDX_W + EIDX_W;
   localparam int STORE_DEPTH = 2 ** ADDR_W;

   localparam logic [CIDX_W-1:0]   LIST_LAST   = CIDX_W'(NUM_LISTS - 1);
   localparam logic [CIDX_W:0]     LIST_COUNT  = (CIDX_W + 1)'(NUM_LISTS);
   localparam logic [EIDX_W:0]     DIM_COUNT   = (EIDX_W + 1)'(VEC_DIM);
   localparam logic [ACTIVE_W-1:0] ACTIVE_MAX  = ACTIVE_W'(NUM_LISTS);
   localparam logic [ACTIVE_W-1:0] ACTIVE_MIN  = ACTIVE_W'(1);
   localparam logic [SUM_W-1:0]    SUM_MAX     = {SUM_W{1'b1}};

   // Item commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic              load;        // write one centroid element
      logic              capture;     // latch the query element
      logic              issue;       // read one centroid of the sweep
      logic [CIDX_W-1:0] issue_index; // centroid read this cycle
      logic              emit;        // move the winner to the output register
   } ncq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pipe_busy;   // sweep reads still in flight
      logic query_last;  // latched element closes the query
      logic out_free;    // output register can take a result
   } ncq_status_type;

endpackage

[hdl/ncq_req_if.sv]
// ----------------------------------------------------------------------------
// Nearest centroid quantizer request channel
// Valid/ready stream carrying one load or query element per transfer.
// ----------------------------------------------------------------------------
interface ncq_req_if import ncq_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [CIDX_W-1:0]         centroid_index;
   logic [EIDX_W-1:0]         element_index;
   logic signed [VALUE_W-1:0] value;
   logic                      last;

   modport source (output valid, cmd, centroid_index, element_index, value, last,
                   input ready);
   modport sink   (input valid, cmd, centroid_index, element_index, value, last,
                   output ready);
endinterface

[hdl/ncq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Nearest centroid quantizer response channel
// Valid/ready stream carrying the winning centroid and its distance.
// ----------------------------------------------------------------------------
interface ncq_rsp_if import ncq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CIDX_W-1:0] best_index;
   logic [SUM_W-1:0]  best_distance;

   modport source (output valid, best_index, best_distance, input ready);
   modport sink   (input valid, best_index, best_distance, output ready);
endinterface

[hdl/ncq_ctrl.sv]
// ----------------------------------------------------------------------------
// Nearest centroid quantizer controller
// Accepts items, sequences the per-centroid sweep and the result hand-off.
// ----------------------------------------------------------------------------
module ncq_ctrl import ncq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_cmd,
   output logic           req_ready,
   input  ncq_status_type status,
   output ncq_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CIDX_W-1:0] cnt_ff, cnt_in;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cmd             = '0;
      cmd.issue_index = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && (req_cmd == CMD_LOAD);
            cmd.capture = accept && (req_cmd == CMD_QUERY);
            if (cmd.capture) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
            end
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LIST_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = status.query_last ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            // hold the winner until the output register frees up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_query_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_QUERY) |=> (state_ff == ST_SWEEP && cnt_ff == '0))
      else $error("query transfer did not start a sweep");

   a_sweep_covers_all: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && cnt_ff != LIST_LAST) |=> (state_ff == ST_SWEEP))
      else $error("sweep ended before the last centroid");

endmodule

[hdl/ncq_datapath.sv]
// ----------------------------------------------------------------------------
// Nearest centroid quantizer datapath
// Centroid store, distance pipeline, running sums, winner search and the
// output register.
// ----------------------------------------------------------------------------
module ncq_datapath import ncq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ncq_cmd_type               cmd,
   output ncq_status_type            status,
   input  logic [CIDX_W-1:0]         req_centroid_index,
   input  logic [EIDX_W-1:0]         req_element_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   input  logic                      csr_we,
   input  logic [ACTIVE_W-1:0]       csr_wdata,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [CIDX_W-1:0]         rsp_best_index,
   output logic [SUM_W-1:0]          rsp_best_distance
);

   // Centroid store
   logic signed [VALUE_W-1:0] store_mem [STORE_DEPTH];
   logic                      store_we;
   logic [ADDR_W-1:0]         rd_addr;

   // Latched query element
   logic signed [VALUE_W-1:0] q_value_ff;
   logic [EIDX_W-1:0]         q_eidx_ff;
   logic                      q_last_ff;
   logic                      q_in_range_ff;

   // Sweep pipeline
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      v1_ff, v2_ff, v3_ff;
   logic [CIDX_W-1:0]         idx1_ff, idx2_ff, idx3_ff;
   logic [ADIFF_W-1:0]        adiff_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic signed [VALUE_W:0]   diff;
   logic [VALUE_W:0]          diff_mag;

   // Sums and winner
   logic [SUM_W-1:0]          sums_ff [NUM_LISTS];
   logic [SUM_W:0]            sum_wide;
   logic [SUM_W-1:0]          sum_sat;
   logic [SQ_W-1:0]           addend;
   logic [CIDX_W-1:0]         best_idx_ff;
   logic [SUM_W-1:0]          best_dist_ff;
   logic                      take_best;

   // Configuration and output
   logic [ACTIVE_W-1:0]       active_ff;
   logic [ACTIVE_W-1:0]       active_n;
   logic                      out_valid_ff;
   logic [CIDX_W-1:0]         out_idx_ff;
   logic [SUM_W-1:0]          out_dist_ff;

   assign store_we = cmd.load
                     && ({1'b0, req_centroid_index} < LIST_COUNT)
                     && ({1'b0, req_element_index} < DIM_COUNT);
   assign rd_addr  = {cmd.issue_index, q_eidx_ff};

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[{req_centroid_index, req_element_index}] <= req_value;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_value_ff    <= req_value;
         q_eidx_ff     <= req_element_index;
         q_last_ff     <= req_last;
         q_in_range_ff <= ({1'b0, req_element_index} < DIM_COUNT);
      end
   end

   // Difference magnitude fits in VALUE_W bits: |a - b| <= 2^VALUE_W - 1
   assign diff     = {q_value_ff[VALUE_W-1], q_value_ff}
                     - {rd_data_ff[VALUE_W-1], rd_data_ff};
   assign diff_mag = diff[VALUE_W] ? (VALUE_W + 1)'(-diff) : (VALUE_W + 1)'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= cmd.issue_index;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      adiff_ff <= diff_mag[ADIFF_W-1:0];
      sq_ff    <= SQ_W'(adiff_ff) * SQ_W'(adiff_ff);
   end

   // Accumulate with saturation; an out-of-range element adds nothing
   assign addend   = q_in_range_ff ? sq_ff : '0;
   assign sum_wide = {1'b0, sums_ff[idx3_ff]} + (SUM_W + 1)'(addend);
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   // Ascending sweep with strict compare keeps the lower index on ties
   assign take_best = v3_ff && q_last_ff
                      && ({1'b0, idx3_ff} < active_n)
                      && ((idx3_ff == '0) || (sum_sat < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            sums_ff[i] <= '0;
         end
      end else if (v3_ff) begin
         // clear each sum as the closing element passes it
         sums_ff[idx3_ff] <= q_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_idx_ff  <= idx3_ff;
         best_dist_ff <= sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_MAX;
      end else if (csr_we) begin
         active_ff <= csr_wdata;
      end
   end

   always_comb begin
      priority if (active_ff == '0) begin
         active_n = ACTIVE_MIN;
      end else if (active_ff > ACTIVE_MAX) begin
         active_n = ACTIVE_MAX;
      end else begin
         active_n = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_idx_ff  <= best_idx_ff;
         out_dist_ff <= best_dist_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_best_index    = out_idx_ff;
   assign rsp_best_distance = out_dist_ff;

   assign status.pipe_busy  = v1_ff || v2_ff || v3_ff;
   assign status.query_last = q_last_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_sweep_order: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && $past(v3_ff)) |-> (idx3_ff == $past(idx3_ff) + 1'b1))
      else $error("sums updated out of centroid order");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cmd.emit))
      else $error("result appeared without an emit");

   a_no_capture_mid_sweep: assert property (@(posedge clock) disable iff (reset)
      status.pipe_busy |-> !cmd.capture)
      else $error("query element latched while the sweep was in flight");

endmodule

[hdl/nearest_centroid_quantizer_unit.sv]
// ----------------------------------------------------------------------------
// Nearest centroid quantizer unit
// Squared-Euclidean nearest-centroid search over a table of Q8.8 centroids.
// ----------------------------------------------------------------------------
// A load transfer (cmd = load) writes one centroid element. A query transfer
// (cmd = query) brings one query element; the unit then walks all NUM_LISTS
// centroids through the single read port of the centroid store, one centroid
// per cycle, through a three-stage difference/square/accumulate pipeline, so
// a query element holds ready low until its sweep has drained, and the unit
// takes no new element before it is through with the last one. The last
// element adds a state that hands the winner to the output register; if an
// earlier result still waits there, the unit holds in that hand-off state,
// with ready low, until the receiver takes it. On that element the unit
// returns the lowest-index active centroid with the smallest sum and clears
// every sum. Centroid elements must be loaded before any query reads them.
// Write csr_wdata (active centroid count, 0 reads as 1, values above
// NUM_LISTS read as NUM_LISTS) only while the unit is idle.
// ----------------------------------------------------------------------------
module nearest_centroid_quantizer_unit import ncq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   ncq_req_if.sink             req_port,
   ncq_rsp_if.source           rsp_port,
   input  logic                csr_we,
   input  logic [ACTIVE_W-1:0] csr_wdata
);

   ncq_cmd_type    cmd;
   ncq_status_type status;

   // Sequence transfers and the per-centroid sweep
   ncq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_cmd   (req_port.cmd),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Store, distance arithmetic, winner search and output register
   ncq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_centroid_index (req_port.centroid_index),
      .req_element_index  (req_port.element_index),
      .req_value          (req_port.value),
      .req_last           (req_port.last),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_port.ready),
      .rsp_valid          (rsp_port.valid),
      .rsp_best_index     (rsp_port.best_index),
      .rsp_best_distance  (rsp_port.best_distance)
   );

endmodule
